[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TRDT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TRDT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/trdt_pkg.sv]
// ---------------------------------------------------------------------------
// Triangle raster depth test package
// Shared constants, register indexes and the divider status type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package trdt_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SCREEN_RESET = 7'd64;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam int DIV_DVD_W = 64;
    localparam int DIV_DVS_W = 48;

    localparam logic signed [15:0] DEPTH_FAR = 16'sd32767;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/triangle_raster_depth_test.sv]
// A vertex beat for slot 0 or 1 is stored while idle; the beat for slot 2 also starts setup.
// A covered pixel step uses the shared multiplier and seven passes of the shared divider,
// with normalize shifts between the quotient and weight passes. An uncovered pixel skips the
// divides, and a step with no triangle goes straight to the result. Beats are taken only while idle.
// Reset: synchronous, active low; a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries
// (4096 by default) sets the depth store to far before the first beat is taken.
// ---------------------------------------------------------------------------
// Triangle raster depth test
// Edge-function rasterizer with perspective-correct weights and a depth store,
// built around one shared multiplier and one shared divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_raster_depth_test #(
    parameter int MAX_WIDTH  = trdt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = trdt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [trdt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [trdt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic [1:0]                          i_vertex_slot,
    input  logic signed [15:0]                  i_pos_x,
    input  logic signed [15:0]                  i_pos_y,
    input  logic signed [15:0]                  i_pos_z,
    input  logic [15:0]                         i_pos_w,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [5:0]                          o_frag_x,
    output logic [5:0]                          o_frag_y,
    output logic signed [15:0]                  o_frag_depth,
    output logic [15:0]                         o_weight_a,
    output logic [15:0]                         o_weight_b,
    output logic [15:0]                         o_weight_c,
    output logic                                o_written,
    output logic                                o_done_res
);
    import trdt_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SMUL  = 4'd2;
    localparam logic [3:0] ST_SBOX  = 4'd3;
    localparam logic [3:0] ST_EDGE  = 4'd4;
    localparam logic [3:0] ST_COV   = 4'd5;
    localparam logic [3:0] ST_QDIV  = 4'd6;
    localparam logic [3:0] ST_NORM  = 4'd7;
    localparam logic [3:0] ST_WDIV  = 4'd8;
    localparam logic [3:0] ST_ZMUL  = 4'd9;
    localparam logic [3:0] ST_DDIV  = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    localparam logic [3:0] SMUL_LAST = 4'd9;
    localparam logic [3:0] EDGE_LAST = 4'd11;
    localparam logic [3:0] ZMUL_LAST = 4'd5;

    logic [3:0]               r_state;
    logic [CFG_DATA_W-1:0]    r_sw;
    logic [CFG_DATA_W-1:0]    r_sh;

    logic signed [15:0]       r_cx [3];
    logic signed [15:0]       r_cy [3];
    logic signed [15:0]       r_cz [3];
    logic [15:0]              r_cw [3];
    logic signed [31:0]       r_sx [3];
    logic signed [31:0]       r_sy [3];
    logic signed [15:0]       r_lz [3];
    logic [15:0]              r_lw [3];

    logic                     r_area_nz;
    logic                     r_active;
    logic [XW-1:0]            r_bx0;
    logic [XW-1:0]            r_bx1;
    logic [YW-1:0]            r_by0;
    logic [YW-1:0]            r_by1;
    logic [XW-1:0]            r_cur_x;
    logic [YW-1:0]            r_cur_y;

    logic [XW-1:0]            r_pc;
    logic [YW-1:0]            r_pr;
    logic [AW-1:0]            r_pidx;
    logic                     r_pdone;
    logic                     r_cov;

    logic [3:0]               r_k;
    logic signed [63:0]       r_prod;
    logic                     r_pv;
    logic [3:0]               r_ptag;
    logic signed [63:0]       r_acc;
    logic signed [63:0]       r_e [3];
    logic [63:0]              r_q [3];
    logic [63:0]              r_s;
    logic [DIV_DVS_W-1:0]     r_sp;
    logic [15:0]              r_wt [3];
    logic signed [63:0]       r_num;
    logic signed [15:0]       r_dep;
    logic                     r_dbusy;

    logic signed [15:0]       r_mem [DEPTH];
    logic signed [15:0]       r_mem_q;
    logic [AW-1:0]            r_clr;

    logic                     r_ov;
    logic [5:0]               r_o_x;
    logic [5:0]               r_o_y;
    logic signed [15:0]       r_o_depth;
    logic [15:0]              r_o_wa;
    logic [15:0]              r_o_wb;
    logic [15:0]              r_o_wc;
    logic                     r_o_written;
    logic                     r_o_done;

    logic                     in_acc;
    logic                     out_free;
    logic signed [31:0]       w_eff;
    logic signed [31:0]       h_eff;
    logic signed [31:0]       px;
    logic signed [31:0]       py;
    logic signed [31:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic                     mul_issue;
    logic signed [31:0]       sxj;
    logic signed [31:0]       sxk;
    logic signed [31:0]       syj;
    logic signed [31:0]       syk;
    logic [63:0]              qsel;
    logic signed [15:0]       zsel;
    logic signed [63:0]       zcontrib;

    logic signed [31:0]       mnx;
    logic signed [31:0]       mxx;
    logic signed [31:0]       mny;
    logic signed [31:0]       mxy;
    logic signed [31:0]       bx0;
    logic signed [31:0]       bx1;
    logic signed [31:0]       by0;
    logic signed [31:0]       by1;
    logic                     box_ok;
    logic [31:0]              bx0_u;
    logic [31:0]              bx1_u;
    logic [31:0]              by0_u;
    logic [31:0]              by1_u;

    logic [31:0]              idx_full;
    logic [31:0]              pc32;
    logic [31:0]              pr32;
    logic                     at_xmax;
    logic                     pix_done;

    logic                     div_start;
    t_div_stat                div_stat;
    logic [DIV_DVD_W-1:0]     div_quot;
    logic [DIV_DVD_W-1:0]     div_dvd;
    logic [DIV_DVS_W-1:0]     div_dvs;
    logic signed [63:0]       esel;
    logic [63:0]              eabs;
    logic [63:0]              nabs;
    logic [63:0]              qsel_d;
    logic [63:0]              qsum;
    logic [15:0]              wsat;
    logic signed [15:0]       dsat;

    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic signed [15:0]       mem_wd;
    logic                     mem_re;
    logic                     pass;

    function automatic logic signed [31:0] trunc15(input logic signed [31:0] v);
        logic signed [31:0] m;
        m = -v;
        if (v[31]) begin
            trunc15 = -(m >>> 15);
        end else begin
            trunc15 = v >>> 15;
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_ov || i_out_ready;

    assign w_eff = ({25'b0, r_sw} < 32'(MAX_WIDTH))  ? signed'({25'b0, r_sw}) : 32'(MAX_WIDTH);
    assign h_eff = ({25'b0, r_sh} < 32'(MAX_HEIGHT)) ? signed'({25'b0, r_sh}) : 32'(MAX_HEIGHT);

    assign pc32 = 32'(r_pc);
    assign pr32 = 32'(r_pr);
    assign px   = signed'(pc32 << 15) + 32'sd16384;
    assign py   = signed'(pr32 << 15) + 32'sd16384;

    assign idx_full = 32'(r_cur_y) * 32'(MAX_WIDTH) + 32'(r_cur_x);
    assign at_xmax  = (r_cur_x == r_bx1);
    assign pix_done = at_xmax && (r_cur_y == r_by1);

    // Bounding box from the screen-space corners.
    always_comb begin
        mnx = r_sx[0];
        mxx = r_sx[0];
        mny = r_sy[0];
        mxy = r_sy[0];
        for (int i = 1; i < 3; i++) begin
            if (r_sx[i] < mnx) mnx = r_sx[i];
            if (r_sx[i] > mxx) mxx = r_sx[i];
            if (r_sy[i] < mny) mny = r_sy[i];
            if (r_sy[i] > mxy) mxy = r_sy[i];
        end
        bx0 = trunc15(mnx);
        bx1 = trunc15(mxx);
        by0 = trunc15(mny);
        by1 = trunc15(mxy);
        if (bx0 < 0) bx0 = '0;
        if (by0 < 0) by0 = '0;
        if (bx1 > w_eff - 32'sd1) bx1 = w_eff - 32'sd1;
        if (by1 > h_eff - 32'sd1) by1 = h_eff - 32'sd1;
        box_ok = r_area_nz && (bx0 <= bx1) && (by0 <= by1);
        bx0_u  = unsigned'(bx0);
        bx1_u  = unsigned'(bx1);
        by0_u  = unsigned'(by0);
        by1_u  = unsigned'(by1);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sxj   = r_sx[0];
        sxk   = r_sx[1];
        syj   = r_sy[0];
        syk   = r_sy[1];
        qsel  = r_q[2];
        zsel  = r_lz[2];
        unique case (r_k[3:2])
            2'd0: begin
                sxj = r_sx[1]; syj = r_sy[1]; sxk = r_sx[2]; syk = r_sy[2];
            end
            2'd1: begin
                sxj = r_sx[2]; syj = r_sy[2]; sxk = r_sx[0]; syk = r_sy[0];
            end
            default: begin
                sxj = r_sx[0]; syj = r_sy[0]; sxk = r_sx[1]; syk = r_sy[1];
            end
        endcase
        unique case (r_k[2:1])
            2'd0:    begin qsel = r_q[0]; zsel = r_lz[0]; end
            2'd1:    begin qsel = r_q[1]; zsel = r_lz[1]; end
            default: begin qsel = r_q[2]; zsel = r_lz[2]; end
        endcase
        unique case (r_state)
            ST_SMUL: begin
                unique case (r_k)
                    4'd0: begin mul_a = 32'(r_cx[0]); mul_b = 32'(r_cy[1]) - 32'(r_cy[2]); end
                    4'd1: begin mul_a = 32'(r_cy[0]); mul_b = 32'(r_cx[2]) - 32'(r_cx[1]); end
                    4'd2: begin mul_a = 32'(r_cx[1]); mul_b = 32'(r_cy[2]); end
                    4'd3: begin mul_a = 32'(r_cx[2]); mul_b = 32'(r_cy[1]); end
                    4'd4: begin mul_a = 32'(r_cx[0]) + 32'sd16384; mul_b = w_eff; end
                    4'd5: begin mul_a = 32'(r_cx[1]) + 32'sd16384; mul_b = w_eff; end
                    4'd6: begin mul_a = 32'(r_cx[2]) + 32'sd16384; mul_b = w_eff; end
                    4'd7: begin mul_a = 32'(r_cy[0]) + 32'sd16384; mul_b = h_eff; end
                    4'd8: begin mul_a = 32'(r_cy[1]) + 32'sd16384; mul_b = h_eff; end
                    default: begin mul_a = 32'(r_cy[2]) + 32'sd16384; mul_b = h_eff; end
                endcase
            end
            ST_EDGE: begin
                unique case (r_k[1:0])
                    2'd0:    begin mul_a = px;  mul_b = syj - syk; end
                    2'd1:    begin mul_a = py;  mul_b = sxk - sxj; end
                    2'd2:    begin mul_a = sxj; mul_b = syk; end
                    default: begin mul_a = sxk; mul_b = syj; end
                endcase
            end
            ST_ZMUL: begin
                mul_a = r_k[0] ? signed'(32'(qsel[44:31])) : signed'(32'(qsel[30:0]));
                mul_b = 32'(zsel);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_SMUL: mul_issue = (r_k <= SMUL_LAST);
            ST_EDGE: mul_issue = (r_k <= EDGE_LAST);
            ST_ZMUL: mul_issue = (r_k <= ZMUL_LAST);
            default: mul_issue = 1'b0;
        endcase
    end

    assign zcontrib = r_ptag[0] ? (r_prod <<< 31) : r_prod;

    // Operand selection for the shared divider.
    always_comb begin
        unique case (r_k[1:0])
            2'd0: begin
                esel    = r_e[0];
                div_dvs = DIV_DVS_W'(r_lw[0]);
            end
            2'd1: begin
                esel    = r_e[1];
                div_dvs = DIV_DVS_W'(r_lw[1]);
            end
            default: begin
                esel    = r_e[2];
                div_dvs = DIV_DVS_W'(r_lw[2]);
            end
        endcase
        unique case (r_k[1:0])
            2'd0:    qsel_d = r_q[0];
            2'd1:    qsel_d = r_q[1];
            default: qsel_d = r_q[2];
        endcase
        eabs = esel[63] ? unsigned'(-esel) : unsigned'(esel);
        nabs = r_num[63] ? unsigned'(-r_num) : unsigned'(r_num);
        unique case (r_state)
            ST_QDIV: div_dvd = eabs << 8;
            ST_WDIV: begin
                div_dvd = (qsel_d << 16) + 64'(r_sp[DIV_DVS_W-1:1]);
                div_dvs = r_sp;
            end
            ST_DDIV: begin
                div_dvd = nabs + 64'(r_sp[DIV_DVS_W-1:1]);
                div_dvs = r_sp;
            end
            default: div_dvd = eabs << 8;
        endcase
    end

    assign div_start = ((r_state == ST_QDIV) || (r_state == ST_WDIV) || (r_state == ST_DDIV))
                       && !r_dbusy;

    assign qsum = r_q[0] + r_q[1] + r_q[2];
    assign wsat = (div_quot[63:16] != '0) ? 16'hFFFF : div_quot[15:0];

    always_comb begin
        if (r_num[63]) begin
            dsat = (div_quot > 64'd32768) ? -16'sd32768 : -signed'(div_quot[15:0]);
        end else begin
            dsat = (div_quot > 64'd32767) ? 16'sd32767 : signed'(div_quot[15:0]);
        end
    end

    trdt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    assign pass = r_cov && (r_dep < r_mem_q);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pidx;
        mem_wd = r_dep;
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = DEPTH_FAR;
        end else if ((r_state == ST_FIN) && out_free && pass) begin
            mem_we = 1'b1;
        end
    end

    assign mem_re = in_acc && (i_cmd == CMD_STEP) && r_active;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[idx_full[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_sw      <= SCREEN_RESET;
            r_sh      <= SCREEN_RESET;
            r_area_nz <= 1'b0;
            r_active  <= 1'b0;
            r_bx0     <= '0;
            r_bx1     <= '0;
            r_by0     <= '0;
            r_by1     <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_k       <= '0;
            r_pv      <= 1'b0;
            r_dbusy   <= 1'b0;
            r_ov      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_cx[i] <= '0;
                r_cy[i] <= '0;
                r_cz[i] <= '0;
                r_cw[i] <= '0;
                r_sx[i] <= '0;
                r_sy[i] <= '0;
                r_lz[i] <= '0;
                r_lw[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_REG_SCREEN_WIDTH:  r_sw <= i_cfg_data;
                    CFG_REG_SCREEN_HEIGHT: r_sh <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end

            r_pv   <= mul_issue;
            r_ptag <= r_k;
            if (mul_issue) begin
                r_k <= r_k + 4'd1;
            end

            if (div_start) begin
                r_dbusy <= 1'b1;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    r_k <= '0;
                    if (in_acc) begin
                        if (i_cmd == CMD_LOAD) begin
                            if (i_vertex_slot != 2'd3) begin
                                r_cx[i_vertex_slot] <= i_pos_x;
                                r_cy[i_vertex_slot] <= i_pos_y;
                                r_cz[i_vertex_slot] <= i_pos_z;
                                r_cw[i_vertex_slot] <= i_pos_w;
                            end
                            if (i_vertex_slot == 2'd2) begin
                                r_state <= ST_SMUL;
                            end
                        end else if (!r_active) begin
                            r_pc    <= '0;
                            r_pr    <= '0;
                            r_pdone <= 1'b1;
                            r_cov   <= 1'b0;
                            r_state <= ST_FIN;
                        end else begin
                            r_pc    <= r_cur_x;
                            r_pr    <= r_cur_y;
                            r_pidx  <= idx_full[AW-1:0];
                            r_pdone <= pix_done;
                            if (at_xmax) begin
                                r_cur_x <= r_bx0;
                                r_cur_y <= r_cur_y + 1'b1;
                            end else begin
                                r_cur_x <= r_cur_x + 1'b1;
                            end
                            if (pix_done) begin
                                r_active <= 1'b0;
                            end
                            r_state <= ST_EDGE;
                        end
                    end
                end

                ST_SMUL: begin
                    if (r_pv) begin
                        unique case (r_ptag)
                            4'd0:       r_acc <= r_prod;
                            4'd1, 4'd2: r_acc <= r_acc + r_prod;
                            4'd3:       r_area_nz <= (r_acc - r_prod) != '0;
                            4'd4:       r_sx[0] <= r_prod[31:0] + 32'sd16384;
                            4'd5:       r_sx[1] <= r_prod[31:0] + 32'sd16384;
                            4'd6:       r_sx[2] <= r_prod[31:0] + 32'sd16384;
                            4'd7:       r_sy[0] <= r_prod[31:0] + 32'sd16384;
                            4'd8:       r_sy[1] <= r_prod[31:0] + 32'sd16384;
                            default:    r_sy[2] <= r_prod[31:0] + 32'sd16384;
                        endcase
                        if (r_ptag == SMUL_LAST) begin
                            r_state <= ST_SBOX;
                            r_k     <= '0;
                        end
                    end
                end

                ST_SBOX: begin
                    for (int i = 0; i < 3; i++) begin
                        r_lz[i] <= r_cz[i];
                        r_lw[i] <= (r_cw[i] == '0) ? 16'd1 : r_cw[i];
                    end
                    r_active <= box_ok;
                    if (box_ok) begin
                        r_bx0   <= bx0_u[XW-1:0];
                        r_bx1   <= bx1_u[XW-1:0];
                        r_by0   <= by0_u[YW-1:0];
                        r_by1   <= by1_u[YW-1:0];
                        r_cur_x <= bx0_u[XW-1:0];
                        r_cur_y <= by0_u[YW-1:0];
                    end else begin
                        r_bx0   <= '0;
                        r_bx1   <= '0;
                        r_by0   <= '0;
                        r_by1   <= '0;
                        r_cur_x <= '0;
                        r_cur_y <= '0;
                    end
                    r_state <= ST_IDLE;
                end

                ST_EDGE: begin
                    if (r_pv) begin
                        unique case (r_ptag[1:0])
                            2'd0:       r_acc <= r_prod;
                            2'd1, 2'd2: r_acc <= r_acc + r_prod;
                            default:    r_e[r_ptag[3:2]] <= r_acc - r_prod;
                        endcase
                        if (r_ptag == EDGE_LAST) begin
                            r_state <= ST_COV;
                            r_k     <= '0;
                        end
                    end
                end

                ST_COV: begin
                    r_k <= '0;
                    if ((r_e[0][63] == r_e[1][63]) && (r_e[1][63] == r_e[2][63])) begin
                        r_state <= ST_QDIV;
                    end else begin
                        r_cov   <= 1'b0;
                        r_state <= ST_FIN;
                    end
                end

                ST_QDIV: begin
                    if (div_stat.done) begin
                        r_dbusy <= 1'b0;
                        r_k     <= r_k + 4'd1;
                        unique case (r_k[1:0])
                            2'd0: r_q[0] <= div_quot;
                            2'd1: r_q[1] <= div_quot;
                            default: begin
                                r_q[2]  <= div_quot;
                                r_s     <= r_q[0] + r_q[1] + div_quot;
                                r_state <= ST_NORM;
                            end
                        endcase
                    end
                end

                ST_NORM: begin
                    r_k <= '0;
                    if (r_s[63:45] != '0) begin
                        r_s <= r_s >> 1;
                        for (int i = 0; i < 3; i++) begin
                            r_q[i] <= r_q[i] >> 1;
                        end
                    end else if (qsum == '0) begin
                        r_cov   <= 1'b0;
                        r_state <= ST_FIN;
                    end else begin
                        r_sp    <= qsum[DIV_DVS_W-1:0];
                        r_state <= ST_WDIV;
                    end
                end

                ST_WDIV: begin
                    if (div_stat.done) begin
                        r_dbusy <= 1'b0;
                        r_k     <= r_k + 4'd1;
                        unique case (r_k[1:0])
                            2'd0: r_wt[0] <= wsat;
                            2'd1: r_wt[1] <= wsat;
                            default: begin
                                r_wt[2] <= wsat;
                                r_k     <= '0;
                                r_state <= ST_ZMUL;
                            end
                        endcase
                    end
                end

                ST_ZMUL: begin
                    if (r_pv) begin
                        unique case (r_ptag)
                            4'd0:      r_acc <= zcontrib;
                            ZMUL_LAST: r_num <= r_acc + zcontrib;
                            default:   r_acc <= r_acc + zcontrib;
                        endcase
                        if (r_ptag == ZMUL_LAST) begin
                            r_state <= ST_DDIV;
                            r_k     <= '0;
                        end
                    end
                end

                ST_DDIV: begin
                    if (div_stat.done) begin
                        r_dbusy <= 1'b0;
                        r_dep   <= dsat;
                        r_cov   <= 1'b1;
                        r_state <= ST_FIN;
                    end
                end

                ST_FIN: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_o_x       <= pc32[5:0];
                        r_o_y       <= pr32[5:0];
                        r_o_done    <= r_pdone;
                        r_o_depth   <= r_cov ? r_dep : '0;
                        r_o_wa      <= r_cov ? r_wt[0] : '0;
                        r_o_wb      <= r_cov ? r_wt[1] : '0;
                        r_o_wc      <= r_cov ? r_wt[2] : '0;
                        r_o_written <= pass;
                        r_state     <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_ov;
    assign o_frag_x     = r_o_x;
    assign o_frag_y     = r_o_y;
    assign o_frag_depth = r_o_depth;
    assign o_weight_a   = r_o_wa;
    assign o_weight_b   = r_o_wb;
    assign o_weight_c   = r_o_wc;
    assign o_written    = r_o_written;
    assign o_done_res   = r_o_done;

    `include "assert_macros.svh"

    `TRDT_ASSERT_IMP(a_no_beat_in_clear, r_state == ST_CLEAR, !o_in_ready, "beat taken during clear")
    `TRDT_ASSERT_IMP(a_div_free, div_start, !div_stat.busy, "divider restarted while busy")
    `TRDT_ASSERT_IMP(a_written_weights, o_out_valid && o_written, (o_weight_a != '0) || (o_weight_b != '0) || (o_weight_c != '0), "written pixel without weight")

endmodule

[rtl/trdt_div.sv]
// ---------------------------------------------------------------------------
// Shared restoring divider
// Unsigned divide, one quotient bit per cycle, with a one-cycle done pulse.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trdt_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [trdt_pkg::DIV_DVD_W-1:0]      i_dividend,
    input  logic [trdt_pkg::DIV_DVS_W-1:0]      i_divisor,
    output trdt_pkg::t_div_stat                 o_stat,
    output logic [trdt_pkg::DIV_DVD_W-1:0]      o_quot
);
    import trdt_pkg::*;

    localparam int CNT_W = $clog2(DIV_DVD_W + 1);

    logic [DIV_DVS_W:0]   r_rem;
    logic [DIV_DVD_W-1:0] r_quo;
    logic [DIV_DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DVS_W:0]   trial;
    logic                 fits;

    assign trial = {r_rem[DIV_DVS_W-1:0], r_quo[DIV_DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_DVD_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
                r_quo <= {r_quo[DIV_DVD_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule

[tb/tb_triangle_raster_depth_test.sv]
// ---------------------------------------------------------------------------
// Triangle raster depth test testbench
// Drives vertex loads, pixel steps and screen size writes with random gaps and output stalls,
// predicts every fragment with a fixed-point model of the rasterizer and its
// depth store, and compares each result beat field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_raster_depth_test;

    import trdt_pkg::*;

    localparam logic [1:0] SLOT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_SPARE_B = 2'd3;
    localparam int STORE_W = DEF_MAX_WIDTH;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [5:0]         fx;
        logic [5:0]         fy;
        logic signed [15:0] depth;
        logic [15:0]        wa;
        logic [15:0]        wb;
        logic [15:0]        wc;
        logic               wr;
        logic               last;
    } frag_t;

    class raster_scoreboard;
        int unsigned   scr_w = 64, scr_h = 64;
        int            vx[3], vy[3], vz[3];
        int unsigned   vw[3];
        longint        sx[3], sy[3];
        int            lz[3];
        longint unsigned lw[3];
        int            bx0, by0, bx1, by1, cx, cy;
        bit            active;
        logic signed [15:0] zbuf[DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
        frag_t         expected_frags[$];
        int            errors, n_checked, n_writes, n_tris, n_steps;

        function new();
            foreach (zbuf[i]) zbuf[i] = DEPTH_FAR;
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d (fragment %0d)",
                     what, got, want, n_checked);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_REG_SCREEN_WIDTH) scr_w = 32'(val);
            else if (idx == CFG_REG_SCREEN_HEIGHT) scr_h = 32'(val);
        endfunction

        function void run_setup();
            int w, h, i;
            longint area, mnx, mxx, mny, mxy;
            w = scr_w < 64 ? scr_w : 64;
            h = scr_h < 64 ? scr_h : 64;
            area = longint'(vx[0]) * (vy[1] - vy[2]) + longint'(vy[0]) * (vx[2] - vx[1])
                 + longint'(vx[1]) * vy[2] - longint'(vx[2]) * vy[1];
            for (i = 0; i < 3; i++) begin
                sx[i] = (longint'(vx[i]) + 16384) * w + 16384;
                sy[i] = (longint'(vy[i]) + 16384) * h + 16384;
                lz[i] = vz[i];
                lw[i] = vw[i] != 0 ? vw[i] : 1;
            end
            mnx = sx[0]; mxx = sx[0]; mny = sy[0]; mxy = sy[0];
            for (i = 1; i < 3; i++) begin
                if (sx[i] < mnx) mnx = sx[i];
                if (sx[i] > mxx) mxx = sx[i];
                if (sy[i] < mny) mny = sy[i];
                if (sy[i] > mxy) mxy = sy[i];
            end
            mnx = mnx / 32768; mxx = mxx / 32768;
            mny = mny / 32768; mxy = mxy / 32768;
            if (mnx < 0) mnx = 0;
            if (mny < 0) mny = 0;
            if (mxx > w - 1) mxx = w - 1;
            if (mxy > h - 1) mxy = h - 1;
            active = area != 0 && mnx <= mxx && mny <= mxy;
            if (active) begin
                bx0 = mnx; by0 = mny; bx1 = mxx; by1 = mxy;
            end else begin
                bx0 = 0; by0 = 0; bx1 = 0; by1 = 0;
            end
            cx = bx0;
            cy = by0;
            n_tris++;
        endfunction

        function void note_input(logic cmd, logic [1:0] slot, logic signed [15:0] x,
                                 logic signed [15:0] y, logic signed [15:0] z,
                                 logic [15:0] w);
            frag_t f;
            longint e[3], px, py, num, dep;
            longint unsigned q[3], s, sp, wt, m;
            int i, j, k, neg, pos, sh, c, r;
            f = '0;
            if (cmd == CMD_LOAD) begin
                if (slot != SLOT_UNUSED) begin
                    vx[slot] = x; vy[slot] = y; vz[slot] = z; vw[slot] = w;
                    if (slot == 2) run_setup();
                end
                return;
            end
            n_steps++;
            if (!active) begin
                f.last = 1'b1;
                expected_frags.push_back(f);
                return;
            end
            c = cx;
            r = cy;
            f.last = (c == bx1 && r == by1);
            if (c < bx1) cx = c + 1;
            else begin
                cx = bx0;
                cy = r + 1;
            end
            if (f.last) active = 0;
            f.fx = c[5:0];
            f.fy = r[5:0];
            px = longint'(c) * 32768 + 16384;
            py = longint'(r) * 32768 + 16384;
            neg = 0; pos = 0;
            for (i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                e[i] = px * (sy[j] - sy[k]) + py * (sx[k] - sx[j])
                     + sx[j] * sy[k] - sx[k] * sy[j];
                if (e[i] < 0) neg++; else pos++;
            end
            if (neg == 3 || pos == 3) begin
                s = 0;
                for (i = 0; i < 3; i++) begin
                    m = e[i] < 0 ? -e[i] : e[i];
                    q[i] = (m << 8) / lw[i];
                    s += q[i];
                end
                if (s != 0) begin
                    sh = 0;
                    while ((s >> sh) >= (64'd1 << 45)) sh++;
                    sp = 0;
                    for (i = 0; i < 3; i++) begin
                        q[i] >>= sh;
                        sp += q[i];
                    end
                    if (sp != 0) begin
                        num = 0;
                        for (i = 0; i < 3; i++) begin
                            wt = ((q[i] << 16) + sp / 2) / sp;
                            wt = wt > 65535 ? 65535 : wt;
                            if (i == 0) f.wa = wt[15:0];
                            else if (i == 1) f.wb = wt[15:0];
                            else f.wc = wt[15:0];
                            num += longint'(q[i]) * lz[i];
                        end
                        if (num >= 0) dep = (num + longint'(sp / 2)) / longint'(sp);
                        else dep = -((-num + longint'(sp / 2)) / longint'(sp));
                        if (dep > 32767) dep = 32767;
                        if (dep < -32768) dep = -32768;
                        f.depth = dep[15:0];
                        if (dep < zbuf[r*STORE_W + c]) begin
                            zbuf[r*STORE_W + c] = dep[15:0];
                            f.wr = 1'b1;
                            n_writes++;
                        end
                    end
                end
            end
            expected_frags.push_back(f);
        endfunction

        task check_result(frag_t got);
            frag_t want;
            if (expected_frags.size() == 0) begin
                $display("unexpected fragment beat at x %0d y %0d", got.fx, got.fy);
                errors++;
                return;
            end
            want = expected_frags.pop_front();
            if (got.fx !== want.fx) report("frag_x", got.fx, want.fx);
            if (got.fy !== want.fy) report("frag_y", got.fy, want.fy);
            if (got.depth !== want.depth) report("frag_depth", got.depth, want.depth);
            if (got.wa !== want.wa) report("weight_a", got.wa, want.wa);
            if (got.wb !== want.wb) report("weight_b", got.wb, want.wb);
            if (got.wc !== want.wc) report("weight_c", got.wc, want.wc);
            if (got.wr !== want.wr) report("written", got.wr, want.wr);
            if (got.last !== want.last) report("done_res", got.last, want.last);
            n_checked++;
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_cmd = CMD_LOAD;
    logic [1:0]              i_vertex_slot = '0;
    logic signed [15:0]      i_pos_x = '0;
    logic signed [15:0]      i_pos_y = '0;
    logic signed [15:0]      i_pos_z = '0;
    logic [15:0]             i_pos_w = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [5:0]              o_frag_x;
    logic [5:0]              o_frag_y;
    logic signed [15:0]      o_frag_depth;
    logic [15:0]             o_weight_a;
    logic [15:0]             o_weight_b;
    logic [15:0]             o_weight_c;
    logic                    o_written;
    logic                    o_done_res;

    raster_scoreboard sb = new();
    int unsigned cycles;

    triangle_raster_depth_test dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_frag_x, o_frag_y, o_frag_depth, o_weight_a, o_weight_b,
                             o_weight_c, o_written, o_done_res});
    end

    // Output stalls, with one long hold-off so that the block backs up.
    initial begin
        int unsigned r;
        bit held;
        held = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (!held && sb.n_checked >= 30) begin
                i_out_ready <= 1'b0;
                repeat (4000) @(posedge i_clk);
                held = 1;
            end else if (r < 60) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else if (r < 93) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(20, 300)) @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_item(logic cmd, logic [1:0] slot, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [15:0] w);
        int gap;
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_vertex_slot <= slot;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pos_z       <= z;
        i_pos_w       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(cmd, slot, x, y, z, w);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic step_pixels(int n);
        repeat (n) send_item(CMD_STEP, 2'($urandom_range(0, 3)), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_in_valid  <= 1'b0;
        while (sb.expected_frags.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] near(int center);
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'(center + int'($urandom_range(0, 3000)) - 1500);
    endfunction

    task automatic random_triangle();
        int cx, cy, i;
        cx = int'($urandom_range(0, 32767)) - 16384;
        cy = int'($urandom_range(0, 32767)) - 16384;
        for (i = 0; i < 3; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_LOAD, SLOT_UNUSED, 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
            send_item(CMD_LOAD, 2'(i), near(cx), near(cy), 16'($urandom),
                      $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024)));
        end
        step_pixels($urandom_range(0, 9) == 0 ? $urandom_range(15, 30) : $urandom_range(1, 8));
    endtask

    initial begin
        int p, budget;
        logic [CFG_DATA_W-1:0] widths[6] = '{7'd1, 7'd127, 7'd8, 7'd0, 7'd33, 7'd64};
        logic [CFG_DATA_W-1:0] heights[6] = '{7'd1, 7'd127, 7'd5, 7'd3, 7'd64, 7'd17};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset screen size.
        send_item(CMD_STEP, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(CMD_LOAD, SLOT_UNUSED, 16'h8000, 16'h7fff, 16'h8000, 16'hffff);
        send_item(CMD_LOAD, 2'd0, 16'd100, 16'd100, 16'd0, 16'd256);
        send_item(CMD_LOAD, 2'd1, 16'd100, 16'd100, 16'd0, 16'd256);
        send_item(CMD_LOAD, 2'd2, 16'd100, 16'd100, 16'd0, 16'd256);
        send_item(CMD_STEP, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(CMD_LOAD, 2'd0, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        send_item(CMD_LOAD, 2'd1, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
        send_item(CMD_LOAD, 2'd2, 16'h8000, 16'h7fff, 16'h0000, 16'h0100);
        step_pixels(3);
        send_item(CMD_LOAD, 2'd0, 16'h1234, 16'h4321, 16'h7fff, 16'h0001);
        step_pixels(2);
        for (p = 0; p < 2; p++) begin
            send_item(CMD_LOAD, 2'd0, -16'sd600, -16'sd600, 16'sd2000, 16'd256);
            send_item(CMD_LOAD, 2'd1, 16'sd600, -16'sd600, -16'sd3000, 16'd512);
            send_item(CMD_LOAD, 2'd2, -16'sd600, 16'sd600, 16'sd100, 16'd128);
            step_pixels(7);
        end
        step_pixels(1);

        budget = 100;
        while (budget > 0) begin
            random_triangle();
            budget -= 10;
        end
        for (p = 0; p < 6; p++) begin
            write_cfg(CFG_REG_SCREEN_WIDTH, widths[p]);
            write_cfg(CFG_REG_SCREEN_HEIGHT, heights[p]);
            if (p == 2) begin
                write_cfg(CFG_REG_SPARE_A, 7'($urandom));
                write_cfg(CFG_REG_SPARE_B, 7'($urandom));
            end
            budget = 85;
            while (budget > 0) begin
                random_triangle();
                budget -= 10;
            end
        end
        i_in_valid <= 1'b0;
        while (sb.expected_frags.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (sb.expected_frags.size() != 0) begin
            $display("%0d expected fragments never arrived", sb.expected_frags.size());
            sb.errors++;
        end
        $display("Covered %0d triangle setups and %0d pixel steps over seven screen sizes;",
                 sb.n_tris, sb.n_steps);
        $display("%0d fragments compared, %0d depth store writes, %0d mismatches.",
                 sb.n_checked, sb.n_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
